>>> design/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // width of the signed input integer, two's complement
    localparam int INPUT_WIDTH = 32;

    // decimal digits needed for the largest magnitude, 2^(INPUT_WIDTH-1)
    function automatic int calc_digits(input int w);
        logic [127:0] lim;
        logic [127:0] p;
        int           d;
        lim = 128'd1 << (w - 1);
        p   = 128'd10;
        d   = 1;
        while (p <= lim) begin
            p = p * 128'd10;
            d = d + 1;
        end
        return d;
    endfunction

    localparam int NUM_DIGITS = calc_digits(INPUT_WIDTH);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = (INPUT_WIDTH > 1) ? $clog2(INPUT_WIDTH) : 1;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // output character codes
    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_SIGN,
        S_DIGIT
    } t_state;

    // commands from the sequencer to the shift-add-3 unit
    typedef struct packed {
        logic load;        // take a new magnitude, clear the digit register
        logic step;        // one shift-add-3 iteration
        logic shift_digit; // drop the top digit, shift the next one up
    } t_dab_cmd;

endpackage

>>> design/sitda_dabble.sv
// ----------------------------------------------------------------------------
// sitda_dabble
// Shift-add-3 unit: holds the binary magnitude and the packed decimal digits,
// runs one conversion iteration per command and shifts digits out on demand.
// ----------------------------------------------------------------------------
module sitda_dabble import sitda_pkg::*; (
    input  logic                   i_clk,
    input  t_dab_cmd               i_cmd,
    input  logic [INPUT_WIDTH-1:0] i_mag,
    output logic [3:0]             o_top_digit
);

    logic [INPUT_WIDTH-1:0] r_bin;
    logic [INPUT_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BCD_W-1:0]       adj_bcd;

    // add 3 to every digit of 5 or more, each digit on its own
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // next value of the working registers
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_bin = i_mag;
            n_bcd = '0;
        end else if (i_cmd.step) begin
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[INPUT_WIDTH-1]};
            n_bin = {r_bin[INPUT_WIDTH-2:0], 1'b0};
        end else if (i_cmd.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

>>> design/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: takes one number, runs the conversion iterations, trims leading
// zeros and then hands out the sign and digits one transfer at a time.
// ----------------------------------------------------------------------------
module sitda_ctrl import sitda_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INPUT_WIDTH-1:0] i_number,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CHAR_W-1:0]      o_char_code,
    output logic                   o_last_char,
    output t_dab_cmd               o_cmd,
    output logic [INPUT_WIDTH-1:0] o_mag,
    input  logic [3:0]             i_top_digit
);

    t_state               r_state;
    t_state               n_state;
    logic                 r_neg;
    logic                 n_neg;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [BIT_CNT_W-1:0] n_bit;
    logic [DIG_CNT_W-1:0] r_dig;
    logic [DIG_CNT_W-1:0] n_dig;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 trim_more;

    assign in_xfer   = i_valid && o_ready;
    assign out_xfer  = o_valid && i_ready;
    assign trim_more = (i_top_digit == 4'd0) && (r_dig != DIG_CNT_W'(1));

    // true magnitude; the most negative value maps to 2^(W-1) exactly
    assign o_mag = i_number[INPUT_WIDTH-1] ? (~i_number + 1'b1) : i_number;

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_bit   = r_bit;
        n_dig   = r_dig;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CONV;
                    n_neg   = i_number[INPUT_WIDTH-1];
                    n_bit   = BIT_CNT_W'(INPUT_WIDTH - 1);
                end
            end
            S_CONV: begin
                if (r_bit == '0) begin
                    n_state = S_TRIM;
                    n_dig   = DIG_CNT_W'(NUM_DIGITS);
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_TRIM: begin
                if (trim_more) begin
                    n_dig = r_dig - 1'b1;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_SIGN: begin
                if (out_xfer) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_xfer) begin
                    n_dig = r_dig - 1'b1;
                    if (r_dig == DIG_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // handshake, character and datapath commands
    always_comb begin
        o_ready           = 1'b0;
        o_valid           = 1'b0;
        o_char_code       = ASCII_ZERO + CHAR_W'(i_top_digit);
        o_last_char       = 1'b0;
        o_cmd             = '0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = in_xfer;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
            end
            S_TRIM: begin
                o_cmd.shift_digit = trim_more;
            end
            S_SIGN: begin
                o_valid     = 1'b1;
                o_char_code = ASCII_MINUS;
            end
            S_DIGIT: begin
                o_valid           = 1'b1;
                o_last_char       = (r_dig == DIG_CNT_W'(1));
                o_cmd.shift_digit = out_xfer;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
            r_bit   <= '0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_bit   <= n_bit;
            r_dig   <= n_dig;
        end
    end

    // a digit on the output is always a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (i_top_digit <= 4'd9))
        else $error("digit out of range on output");

    // an accepted number starts the conversion
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CONV))
        else $error("conversion did not start after input transfer");

    // the sign is only sent for a negative number
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> r_neg)
        else $error("minus sign for a non-negative number");

    // a leading digit is never zero unless it is the only digit
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TRIM) && (n_state != S_TRIM)) |->
            ((i_top_digit != 4'd0) || (r_dig == DIG_CNT_W'(1))))
        else $error("leading zero left after trim");

endmodule

>>> design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer into its decimal ASCII text, one character
// per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Accepts one INPUT_WIDTH-bit two's complement number at a time and returns
// its text: a '-' (code 45) for negative values, then the digits '0' to '9'
// (codes 48 to 57) with no leading zeros, the final character flagged by
// o_last_char. Every value converts exactly, the most negative one too. The
// magnitude goes through a shift-add-3 unit one bit per cycle, then the
// leading zeros are removed one at a time and the characters go out one
// per cycle while the sink is ready. o_ready is high only while the block
// is empty.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sitda_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INPUT_WIDTH-1:0] i_number,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CHAR_W-1:0]      o_char_code,
    output logic                   o_last_char
);

    t_dab_cmd               dab_cmd;
    logic [INPUT_WIDTH-1:0] mag;
    logic [3:0]             top_digit;

    // sequencer and output handshake
    sitda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .o_cmd       (dab_cmd),
        .o_mag       (mag),
        .i_top_digit (top_digit)
    );

    // shift-add-3 unit driven by the sequencer
    sitda_dabble u_dabble (
        .i_clk       (i_clk),
        .i_cmd       (dab_cmd),
        .i_mag       (mag),
        .o_top_digit (top_digit)
    );

endmodule
